// ===== sv/text_console_cell_buffer_assert.svh =====
// ----------------------------------------------------------------------------
// text console cell buffer assertion macros
// shared property forms for the console buffer checks
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_BUFFER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_BUFFER_ASSERT_SVH

// consequent checked in the same cycle
`define TCCB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tccb check failed");

// consequent checked in the next cycle
`define TCCB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tccb check failed");

`endif

// ===== sv/tccb_pkg.sv =====
// ----------------------------------------------------------------------------
// tccb_pkg
// types and constants shared by the text console cell buffer modules
// ----------------------------------------------------------------------------
package tccb_pkg;

    localparam int ROWS_DEF = 25;
    localparam int COLS_DEF = 80;

    localparam int OP_W     = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int IDX_W    = 11;
    localparam int CELL_W   = 16;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 7;
    localparam int OFF_W    = 11;
    localparam int TDATA_W  = 32;
    localparam int APB_AW   = 2;
    localparam int APB_DW   = 32;
    localparam int QDEPTH   = 2;
    localparam int QAW      = 1;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE    = 8'd10;
    localparam logic [CELL_W-1:0] BLANK_RESET     = 16'h2007;
    localparam logic [APB_AW-1:0] ADDR_BLANK_CELL = 2'd0;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE     = 2'd0,
        OP_BACKSPACE = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_READ      = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CMD_PUT,
        CMD_NEWLINE,
        CMD_BACK,
        CMD_CLEAR,
        CMD_READ
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PLAN,
        ST_ADDR,
        ST_MEM,
        ST_SCROLL,
        ST_DONE
    } t_bstate;

    typedef struct packed {
        t_cmd              cmd;
        logic [CHAR_W-1:0] chr;
        logic [ATTR_W-1:0] attr;
        logic [IDX_W-1:0]  idx;
    } t_item;

    typedef struct packed {
        logic  push;
        t_item item;
    } t_q_push;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_out;

    typedef struct packed {
        logic init_busy;
    } t_back_status;

    // first member sits in the high bits
    typedef struct packed {
        logic [CHAR_W-1:0] rd_char;
        logic [OFF_W-1:0]  offset;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } t_result;

endpackage

// ===== sv/tccb_front.sv =====
// ----------------------------------------------------------------------------
// tccb_front
// accepts input transactions, unpacks them and sorts them into commands
// ----------------------------------------------------------------------------
module tccb_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [tccb_pkg::TDATA_W-1:0] i_tdata,
    input  logic [tccb_pkg::OP_W-1:0]    i_tuser,
    input  logic                         i_full,
    input  tccb_pkg::t_back_status       i_status,
    output tccb_pkg::t_q_push            o_push
);

    tccb_pkg::t_op   op;
    tccb_pkg::t_item item;
    logic            r_ready;

    // registered ready: queue full and clearing pass both come from flops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    always_comb begin
        op        = tccb_pkg::t_op'(i_tuser);
        item.chr  = i_tdata[tccb_pkg::CHAR_W-1:0];
        item.attr = i_tdata[tccb_pkg::CHAR_W +: tccb_pkg::ATTR_W];
        item.idx  = i_tdata[tccb_pkg::CHAR_W + tccb_pkg::ATTR_W +: tccb_pkg::IDX_W];
        case (op)
            tccb_pkg::OP_WRITE: begin
                item.cmd = (item.chr == tccb_pkg::NEWLINE_CODE) ?
                           tccb_pkg::CMD_NEWLINE : tccb_pkg::CMD_PUT;
            end
            tccb_pkg::OP_BACKSPACE: item.cmd = tccb_pkg::CMD_BACK;
            tccb_pkg::OP_CLEAR:     item.cmd = tccb_pkg::CMD_CLEAR;
            tccb_pkg::OP_READ:      item.cmd = tccb_pkg::CMD_READ;
            default:                item.cmd = tccb_pkg::CMD_READ;
        endcase
    end

    assign o_ready     = r_ready && !i_full && !i_status.init_busy;
    assign o_push.push = i_valid && o_ready;
    assign o_push.item = item;

endmodule

// ===== sv/tccb_queue.sv =====
// ----------------------------------------------------------------------------
// tccb_queue
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
module tccb_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tccb_pkg::t_q_push i_push,
    output logic              o_full,
    input  logic              i_pop,
    output tccb_pkg::t_q_out  o_q
);

    tccb_pkg::t_item             r_slot [tccb_pkg::QDEPTH];
    logic [tccb_pkg::QAW-1:0]    r_wp;
    logic [tccb_pkg::QAW-1:0]    r_rp;
    logic [tccb_pkg::QAW:0]      r_count;

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_slot[r_wp] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push.push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full    = (r_count == (tccb_pkg::QAW + 1)'(tccb_pkg::QDEPTH));
    assign o_q.valid = (r_count != '0);
    assign o_q.item  = r_slot[r_rp];

endmodule

// ===== sv/tccb_back.sv =====
// ----------------------------------------------------------------------------
// tccb_back
// cell memory, cursor and the sequencer that carries out each command
// ----------------------------------------------------------------------------
module tccb_back #(
    parameter int ROWS = tccb_pkg::ROWS_DEF,
    parameter int COLS = tccb_pkg::COLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tccb_pkg::CELL_W-1:0] i_blank,
    input  tccb_pkg::t_q_out            i_q,
    output logic                        o_pop,
    output tccb_pkg::t_back_status      o_status,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output tccb_pkg::t_result           o_out
);

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int XW    = ((AW > tccb_pkg::IDX_W) ? AW : tccb_pkg::IDX_W) + 1;

    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(CELLS - 1);
    localparam logic [AW:0]   CELLS_X  = (AW + 1)'(CELLS);
    localparam logic [AW:0]   COLS_X   = (AW + 1)'(COLS);

    // screen store, rotated by r_base so a scroll only blanks one row
    logic [tccb_pkg::CELL_W-1:0] mem [CELLS];

    tccb_pkg::t_bstate r_state, n_state;
    logic                          r_init;
    logic [RW-1:0]                 r_row;
    logic [CW-1:0]                 r_col;
    logic [AW-1:0]                 r_base;
    tccb_pkg::t_item               r_item;
    logic                          r_wr;
    logic                          r_rd;
    logic                          r_scroll;
    logic [tccb_pkg::CELL_W-1:0]   r_wdata;
    logic [AW-1:0]                 r_lin;
    logic [AW-1:0]                 r_addr;
    logic [AW-1:0]                 r_ptr;
    logic [CW-1:0]                 r_cnt;
    logic [tccb_pkg::CELL_W-1:0]   r_rdata;
    logic                          r_out_valid;
    tccb_pkg::t_result             r_out;

    logic [RW-1:0]                 p_row, p_trow;
    logic [CW-1:0]                 p_col, p_tcol;
    logic                          p_wr, p_rd, p_nl, p_scroll, p_use_idx, idx_ok;
    logic [tccb_pkg::CELL_W-1:0]   p_wdata;
    logic [AW-1:0]                 p_lin;
    logic [AW:0]                   a_sum, b_sum;
    logic [AW-1:0]                 a_addr, b_next;
    logic                          m_we;
    logic [AW-1:0]                 m_waddr;
    logic [tccb_pkg::CELL_W-1:0]   m_wdata;
    logic                          out_free;

    // command planning: cursor update and the cell to touch
    always_comb begin
        idx_ok    = (XW'(r_item.idx) < XW'(CELLS));
        p_row     = r_row;
        p_col     = r_col;
        p_trow    = r_row;
        p_tcol    = r_col;
        p_wr      = 1'b0;
        p_rd      = 1'b0;
        p_nl      = 1'b0;
        p_use_idx = 1'b0;
        p_scroll  = 1'b0;
        p_wdata   = {r_item.chr, r_item.attr};
        case (r_item.cmd)
            tccb_pkg::CMD_PUT: begin
                p_wr = 1'b1;
                if (r_col == COL_LAST) begin
                    p_nl = 1'b1;
                end else begin
                    p_col = r_col + 1'b1;
                end
            end
            tccb_pkg::CMD_NEWLINE: p_nl = 1'b1;
            tccb_pkg::CMD_BACK: begin
                p_wdata = i_blank;
                if (r_col != '0) begin
                    p_wr   = 1'b1;
                    p_tcol = r_col - 1'b1;
                    p_col  = r_col - 1'b1;
                end else if (r_row != '0) begin
                    // wrap to the last column of the row above
                    p_wr   = 1'b1;
                    p_trow = r_row - 1'b1;
                    p_tcol = COL_LAST;
                    p_row  = r_row - 1'b1;
                    p_col  = COL_LAST;
                end
            end
            tccb_pkg::CMD_READ: begin
                p_rd      = idx_ok;
                p_use_idx = idx_ok;
            end
            default: ;
        endcase
        if (p_nl) begin
            p_col = '0;
            if (r_row == ROW_LAST) begin
                p_scroll = 1'b1;
            end else begin
                p_row = r_row + 1'b1;
            end
        end
        p_lin = p_use_idx ? AW'(r_item.idx) : AW'(p_trow * COLS + p_tcol);
    end

    // logical to physical cell address, and the base after a scroll
    always_comb begin
        a_sum  = {1'b0, r_lin} + {1'b0, r_base};
        a_addr = (a_sum >= CELLS_X) ? AW'(a_sum - CELLS_X) : AW'(a_sum);
        b_sum  = {1'b0, r_base} + COLS_X;
        b_next = (b_sum == CELLS_X) ? '0 : AW'(b_sum);
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            tccb_pkg::ST_CLEAR: begin
                if (r_ptr == PTR_LAST) begin
                    n_state = r_init ? tccb_pkg::ST_IDLE : tccb_pkg::ST_DONE;
                end
            end
            tccb_pkg::ST_IDLE: begin
                if (i_q.valid) begin
                    n_state = tccb_pkg::ST_PLAN;
                end
            end
            tccb_pkg::ST_PLAN: begin
                n_state = (r_item.cmd == tccb_pkg::CMD_CLEAR) ?
                          tccb_pkg::ST_CLEAR : tccb_pkg::ST_ADDR;
            end
            tccb_pkg::ST_ADDR: n_state = tccb_pkg::ST_MEM;
            tccb_pkg::ST_MEM: begin
                n_state = r_scroll ? tccb_pkg::ST_SCROLL : tccb_pkg::ST_DONE;
            end
            tccb_pkg::ST_SCROLL: begin
                if (r_cnt == COL_LAST) begin
                    n_state = tccb_pkg::ST_DONE;
                end
            end
            tccb_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = tccb_pkg::ST_IDLE;
                end
            end
            default: n_state = tccb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        m_we    = 1'b0;
        m_waddr = r_ptr;
        m_wdata = i_blank;
        o_pop   = 1'b0;
        case (r_state)
            tccb_pkg::ST_CLEAR:  m_we = 1'b1;
            tccb_pkg::ST_SCROLL: m_we = 1'b1;
            tccb_pkg::ST_MEM: begin
                m_we    = r_wr;
                m_waddr = r_addr;
                m_wdata = r_wdata;
            end
            tccb_pkg::ST_IDLE: o_pop = i_q.valid;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            mem[m_waddr] <= m_wdata;
        end
        r_rdata <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tccb_pkg::ST_CLEAR;
            r_init      <= 1'b1;
            r_ptr       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // the done state reloads the output register itself
            if (r_out_valid && i_out_ready && r_state != tccb_pkg::ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                tccb_pkg::ST_IDLE: begin
                    if (i_q.valid) begin
                        r_item <= i_q.item;
                    end
                end
                tccb_pkg::ST_PLAN: begin
                    if (r_item.cmd == tccb_pkg::CMD_CLEAR) begin
                        r_ptr  <= '0;
                        r_row  <= '0;
                        r_col  <= '0;
                        r_base <= '0;
                        r_rd   <= 1'b0;
                    end else begin
                        r_row    <= p_row;
                        r_col    <= p_col;
                        r_lin    <= p_lin;
                        r_wr     <= p_wr;
                        r_rd     <= p_rd;
                        r_scroll <= p_scroll;
                        r_wdata  <= p_wdata;
                    end
                end
                tccb_pkg::ST_ADDR: r_addr <= a_addr;
                tccb_pkg::ST_MEM: begin
                    // old top row becomes the new bottom row
                    r_ptr <= r_base;
                    r_cnt <= '0;
                end
                tccb_pkg::ST_CLEAR: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr == PTR_LAST) begin
                        r_init <= 1'b0;
                    end
                end
                tccb_pkg::ST_SCROLL: begin
                    r_ptr <= r_ptr + 1'b1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == COL_LAST) begin
                        r_base <= b_next;
                    end
                end
                tccb_pkg::ST_DONE: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out.row      <= tccb_pkg::ROW_W'(r_row);
                        r_out.col      <= tccb_pkg::COL_W'(r_col);
                        r_out.offset   <= tccb_pkg::OFF_W'(r_row * COLS + r_col);
                        r_out.rd_char  <= r_rd ? r_rdata[tccb_pkg::CELL_W-1 -: tccb_pkg::CHAR_W]
                                               : '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_status.init_busy = r_init;
    assign o_out_valid        = r_out_valid;
    assign o_out              = r_out;

endmodule

// ===== sv/text_console_cell_buffer.sv =====
// ----------------------------------------------------------------------------
// text_console_cell_buffer
// character cell screen with cursor, scrolling, backspace, clear and read
// ----------------------------------------------------------------------------
// channel   direction  contents
// s_axis    in         tuser: operation; tdata: char_code, attr_color, cell_index
// m_axis    out        tdata: cursor_row, cursor_col, cursor_offset, read_char
// apb       in/out     blank_cell at byte address 0
//
// a write, newline, backspace or read goes from the queue head through the plan,
// address, memory and done states; a scroll adds a pass that blanks the new
// bottom row through the one write port. clear blanks every cell, one cell written
// per cycle. after reset the same pass runs with s_axis_tready low.
// a two-entry queue takes transactions while the sequencer or m_axis is stalled.
// ----------------------------------------------------------------------------
module text_console_cell_buffer #(
    parameter int ROWS = tccb_pkg::ROWS_DEF,
    parameter int COLS = tccb_pkg::COLS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [7:0] char_code, [15:8] attr_color, [26:16] cell_index, [31:27] zero
    input  logic [tccb_pkg::TDATA_W-1:0] s_axis_tdata,
    // [1:0] operation
    input  logic [tccb_pkg::OP_W-1:0]    s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [4:0] cursor_row, [11:5] cursor_col, [22:12] cursor_offset,
    // [30:23] read_char, [31] zero
    output logic [tccb_pkg::TDATA_W-1:0] m_axis_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tccb_pkg::APB_AW-1:0]  paddr,
    input  logic [tccb_pkg::APB_DW-1:0]  pwdata,
    output logic [tccb_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);

    logic [tccb_pkg::CELL_W-1:0] r_blank;
    tccb_pkg::t_q_push           w_push;
    tccb_pkg::t_q_out            w_q;
    tccb_pkg::t_back_status      w_status;
    tccb_pkg::t_result           w_out;
    logic                        w_full;
    logic                        w_pop;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank <= tccb_pkg::BLANK_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr == tccb_pkg::ADDR_BLANK_CELL) begin
            r_blank <= pwdata[tccb_pkg::CELL_W-1:0];
        end
    end

    assign prdata = (paddr == tccb_pkg::ADDR_BLANK_CELL) ?
                    tccb_pkg::APB_DW'(r_blank) : '0;

    tccb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_full   (w_full),
        .i_status (w_status),
        .o_push   (w_push)
    );

    tccb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_q     (w_q)
    );

    tccb_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_blank     (r_blank),
        .i_q         (w_q),
        .o_pop       (w_pop),
        .o_status    (w_status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out       (w_out)
    );

    assign m_axis_tdata = {1'b0, w_out};

`include "text_console_cell_buffer_assert.svh"

    `TCCB_ASSERT_SAME(a_col_range, m_axis_tvalid, m_axis_tdata[11:5] < COLS)
    `TCCB_ASSERT_SAME(a_row_range, m_axis_tvalid, m_axis_tdata[4:0] < ROWS)
    `TCCB_ASSERT_SAME(a_init_blocks_input, w_status.init_busy, !s_axis_tready)
    `TCCB_ASSERT_NEXT(a_push_lands, s_axis_tvalid && s_axis_tready, w_q.valid)

endmodule
